// ----- src/spnh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spnh_pkg
// Shared constants and types for the shortest-path next-hop block.
// ----------------------------------------------------------------------------
package spnh_pkg;

  localparam int MAX_GRAPH_NODES_DEF = 16;
  localparam int WEIGHT_BITS_DEF     = 8;

  localparam int NODE_BITS  = 4;
  localparam int CFG_BITS   = 5;
  localparam int EDGE_BITS  = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  typedef enum logic {
    ALU_SELECT,
    ALU_RELAX
  } spnh_alu_mode_t;

endpackage

// ----- src/spnh_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spnh_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module spnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/spnh_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spnh_alu
// Shared cost unit: path-cost adder and one magnitude comparator.
// ----------------------------------------------------------------------------
module spnh_alu #(
  parameter int COST_BITS   = 12,
  parameter int WEIGHT_BITS = 8
) (
  input  spnh_pkg::spnh_alu_mode_t mode,
  input  logic [COST_BITS-1:0]     best,
  input  logic [WEIGHT_BITS-1:0]   weight,
  input  logic [COST_BITS-1:0]     cost_rd,
  output logic [COST_BITS-1:0]     sum,
  output logic                     lt
);
  import spnh_pkg::*;

  logic [COST_BITS-1:0] cmp_a;
  logic [COST_BITS-1:0] cmp_b;

  assign sum = best + COST_BITS'(weight);

  // select: stored cost against running minimum; relax: new cost against stored
  always_comb begin
    case (mode)
      ALU_RELAX: begin
        cmp_a = sum;
        cmp_b = cost_rd;
      end
      default: begin
        cmp_a = cost_rd;
        cmp_b = best;
      end
    endcase
  end

  assign lt = (cmp_a < cmp_b);

endmodule

// ----- src/shortest_path_next_hop.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_path_next_hop
// Dense-matrix Dijkstra search returning the first hop towards the end node.
// ----------------------------------------------------------------------------
// Write transaction: accepted back to back, no result.
// Solve transaction: an init state, per settled node a search scan and a
// relax scan, a final search scan, a read and a check state per hop of the
// walk back and an output state; input stalled throughout.
// Reset: the weight RAM is swept to zero, one entry per cycle, over all
// MAX_GRAPH_NODES squared entries, with the input stalled; node_count = 1.
// ----------------------------------------------------------------------------
module shortest_path_next_hop #(
  parameter int MAX_GRAPH_NODES = spnh_pkg::MAX_GRAPH_NODES_DEF,
  parameter int WEIGHT_BITS     = spnh_pkg::WEIGHT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [spnh_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           operation,
  input  logic [spnh_pkg::NODE_BITS-1:0] row_node,
  input  logic [spnh_pkg::NODE_BITS-1:0] col_node,
  input  logic [spnh_pkg::EDGE_BITS-1:0] edge_weight,
  input  logic [spnh_pkg::NODE_BITS-1:0] start_node,
  input  logic [spnh_pkg::NODE_BITS-1:0] end_node,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [spnh_pkg::NODE_BITS-1:0] next_node,
  output logic                           no_path
);
  import spnh_pkg::*;

  localparam int IDXW   = $clog2(MAX_GRAPH_NODES);
  localparam int CNTW   = $clog2(MAX_GRAPH_NODES + 1);
  localparam int CMPW   = (CNTW > CFG_BITS) ? CNTW : CFG_BITS;
  localparam int DEPTH  = MAX_GRAPH_NODES * MAX_GRAPH_NODES;
  localparam int ADDRW  = $clog2(DEPTH);
  localparam int COSTW  = WEIGHT_BITS + IDXW;

  localparam logic [CMPW-1:0]  MAXV      = CMPW'(MAX_GRAPH_NODES);
  localparam logic [ADDRW-1:0] ROW_PITCH = ADDRW'(MAX_GRAPH_NODES);
  localparam logic [ADDRW-1:0] CLR_LAST  = ADDRW'(DEPTH - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SELECT,
    ST_SEL_WAIT,
    ST_SEL_DONE,
    ST_RELAX,
    ST_RLX_WAIT,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_OUT
  } state_t;

  state_t                     state;
  logic [CFG_BITS-1:0]        node_count;
  logic [ADDRW-1:0]           clr;
  logic [CNTW-1:0]            n_eff;
  logic [IDXW-1:0]            start_n;
  logic [IDXW-1:0]            end_n;
  logic [IDXW-1:0]            idx;
  logic                       p_valid;
  logic [IDXW-1:0]            p_idx;
  logic                       found;
  logic [COSTW-1:0]           best;
  logic [IDXW-1:0]            u;
  logic [MAX_GRAPH_NODES-1:0] done_v;
  logic [MAX_GRAPH_NODES-1:0] reach_v;
  logic [IDXW-1:0]            cur;
  logic [NODE_BITS-1:0]       res_node;
  logic                       res_np;

  logic                 accept;
  logic                 idx_last;
  logic [CMPW-1:0]      cnt_ext;
  logic [CMPW-1:0]      n_calc;
  logic [CMPW-1:0]      s_ext;
  logic [CMPW-1:0]      e_ext;
  logic [IDXW-1:0]      start_c;
  logic [IDXW-1:0]      end_c;
  logic                 wr_in_range;
  spnh_alu_mode_t       alu_mode;
  logic [COSTW-1:0]     sum;
  logic                 lt;
  logic                 sel_ok;
  logic                 relax_ok;
  logic                 relax_stage;

  logic                 wt_we;
  logic [ADDRW-1:0]     wt_waddr;
  logic [WEIGHT_BITS-1:0] wt_wdata;
  logic [ADDRW-1:0]     wt_raddr;
  logic [WEIGHT_BITS-1:0] wt_rdata;
  logic                 cost_we;
  logic [IDXW-1:0]      cost_waddr;
  logic [COSTW-1:0]     cost_wdata;
  logic [COSTW-1:0]     cost_rdata;
  logic                 pred_we;
  logic [IDXW-1:0]      pred_rdata;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign idx_last = (CNTW'(idx) == n_eff - CNTW'(1));

  // effective node count and index clamping
  always_comb begin
    cnt_ext = CMPW'(node_count);
    if (cnt_ext == '0) begin
      n_calc = CMPW'(1);
    end else if (cnt_ext > MAXV) begin
      n_calc = MAXV;
    end else begin
      n_calc = cnt_ext;
    end
    s_ext   = CMPW'(start_node);
    e_ext   = CMPW'(end_node);
    start_c = (s_ext >= n_calc) ? IDXW'(n_calc - CMPW'(1)) : IDXW'(s_ext);
    end_c   = (e_ext >= n_calc) ? IDXW'(n_calc - CMPW'(1)) : IDXW'(e_ext);
  end

  assign wr_in_range = (CMPW'(row_node) < MAXV) && (CMPW'(col_node) < MAXV);

  assign alu_mode = ((state == ST_RELAX) || (state == ST_RLX_WAIT)) ? ALU_RELAX
                                                                     : ALU_SELECT;

  spnh_alu #(
    .COST_BITS   (COSTW),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_alu (
    .mode    (alu_mode),
    .best    (best),
    .weight  (wt_rdata),
    .cost_rd (cost_rdata),
    .sum     (sum),
    .lt      (lt)
  );

  assign sel_ok      = !done_v[p_idx] && reach_v[p_idx] && (!found || lt);
  assign relax_ok    = !done_v[p_idx] && (wt_rdata != '0) && (!reach_v[p_idx] || lt);
  assign relax_stage = p_valid && (alu_mode == ALU_RELAX);

  // RAM port control
  always_comb begin
    if (state == ST_CLEAR) begin
      wt_we    = 1'b1;
      wt_waddr = clr;
      wt_wdata = '0;
    end else begin
      wt_we    = accept && (operation == OP_WRITE) && wr_in_range;
      wt_waddr = ADDRW'(row_node) * ROW_PITCH + ADDRW'(col_node);
      wt_wdata = WEIGHT_BITS'(edge_weight);
    end
    wt_raddr = ADDRW'(u) * ROW_PITCH + ADDRW'(idx);

    if (state == ST_INIT) begin
      cost_we    = 1'b1;
      cost_waddr = start_n;
      cost_wdata = '0;
    end else begin
      cost_we    = relax_stage && relax_ok;
      cost_waddr = p_idx;
      cost_wdata = sum;
    end
    pred_we = relax_stage && relax_ok;
  end

  spnh_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (wt_wdata),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

  spnh_ram #(.WIDTH(COSTW), .DEPTH(MAX_GRAPH_NODES)) u_cost_ram (
    .clk   (clk),
    .we    (cost_we),
    .waddr (cost_waddr),
    .wdata (cost_wdata),
    .raddr (idx),
    .rdata (cost_rdata)
  );

  spnh_ram #(.WIDTH(IDXW), .DEPTH(MAX_GRAPH_NODES)) u_pred_ram (
    .clk   (clk),
    .we    (pred_we),
    .waddr (p_idx),
    .wdata (u),
    .raddr (cur),
    .rdata (pred_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr        <= '0;
      node_count <= CFG_BITS'(1);
      out_valid  <= 1'b0;
      p_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        node_count <= cfg_data;
      end

      // read-data stage of the scan pipeline
      p_valid <= (state == ST_SELECT) || (state == ST_RELAX);
      p_idx   <= idx;
      if (p_valid && (alu_mode == ALU_SELECT) && sel_ok) begin
        found <= 1'b1;
        best  <= cost_rdata;
        u     <= p_idx;
      end
      if (relax_stage && relax_ok) begin
        reach_v[p_idx] <= 1'b1;
      end

      if (out_valid && !out_stall && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr <= clr + ADDRW'(1);
          if (clr == CLR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (operation == OP_SOLVE)) begin
            n_eff   <= CNTW'(n_calc);
            start_n <= start_c;
            end_n   <= end_c;
            state   <= ST_INIT;
          end
        end
        ST_INIT: begin
          done_v  <= '0;
          reach_v <= MAX_GRAPH_NODES'(1) << start_n;
          idx     <= '0;
          found   <= 1'b0;
          state   <= ST_SELECT;
        end
        ST_SELECT: begin
          if (idx_last) begin
            state <= ST_SEL_WAIT;
          end else begin
            idx <= idx + IDXW'(1);
          end
        end
        ST_SEL_WAIT: begin
          state <= ST_SEL_DONE;
        end
        ST_SEL_DONE: begin
          if (found) begin
            done_v[u] <= 1'b1;
            idx       <= '0;
            state     <= ST_RELAX;
          end else if (!reach_v[end_n] || (end_n == start_n)) begin
            res_node <= NODE_BITS'(end_n);
            res_np   <= 1'b1;
            state    <= ST_OUT;
          end else begin
            cur   <= end_n;
            state <= ST_WALK_RD;
          end
        end
        ST_RELAX: begin
          if (idx_last) begin
            state <= ST_RLX_WAIT;
          end else begin
            idx <= idx + IDXW'(1);
          end
        end
        ST_RLX_WAIT: begin
          idx   <= '0;
          found <= 1'b0;
          state <= ST_SELECT;
        end
        ST_WALK_RD: begin
          state <= ST_WALK_CHK;
        end
        ST_WALK_CHK: begin
          if (pred_rdata == start_n) begin
            res_node <= NODE_BITS'(cur);
            res_np   <= 1'b0;
            state    <= ST_OUT;
          end else begin
            cur   <= pred_rdata;
            state <= ST_WALK_RD;
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            next_node <= res_node;
            no_path   <= res_np;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- bench/shortest_path_next_hop_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_path_next_hop_tb
// Self-checking bench for the next-hop shortest-path block. Edge-weight
// writes and solve requests flow through a queue-fed driver; a scoreboard
// mirrors the weight matrix and node count and runs its own Dijkstra search
// to work out the next hop for every accepted solve. Phases step through
// node counts (extremes and out-of-range values included) and through
// sender idling and receiver stalling patterns.
// ----------------------------------------------------------------------------
module shortest_path_next_hop_tb;
  import spnh_pkg::*;

  localparam int NODE_LIMIT  = MAX_GRAPH_NODES_DEF;
  localparam int NO_PRED     = NODE_LIMIT;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 20;

  typedef struct packed {
    logic                 op;
    logic [NODE_BITS-1:0] row;
    logic [NODE_BITS-1:0] col;
    logic [EDGE_BITS-1:0] weight;
    logic [NODE_BITS-1:0] src;
    logic [NODE_BITS-1:0] dst;
  } hop_request_t;

  typedef struct packed {
    logic [NODE_BITS-1:0] hop;
    logic                 no_path;
  } hop_result_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_write   = 1'b0;
  logic [CFG_BITS-1:0]  cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic                 operation   = OP_WRITE;
  logic [NODE_BITS-1:0] row_node    = '0;
  logic [NODE_BITS-1:0] col_node    = '0;
  logic [EDGE_BITS-1:0] edge_weight = '0;
  logic [NODE_BITS-1:0] start_node  = '0;
  logic [NODE_BITS-1:0] end_node    = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [NODE_BITS-1:0] next_node;
  logic                 no_path;

  hop_request_t         pending_requests[$];
  hop_result_t          expected_hops[$];
  logic [EDGE_BITS-1:0] weight_model[NODE_LIMIT][NODE_LIMIT];
  logic [CFG_BITS-1:0]  node_cfg;
  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;
  int                   mismatches     = 0;
  int                   quiet_cycles   = 0;

  shortest_path_next_hop dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .row_node   (row_node),
    .col_node   (col_node),
    .edge_weight(edge_weight),
    .start_node (start_node),
    .end_node   (end_node),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .next_node  (next_node),
    .no_path    (no_path)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int effective_nodes(input logic [CFG_BITS-1:0] cfg);
    if (cfg == 0) return 1;
    if (cfg > NODE_LIMIT) return NODE_LIMIT;
    return int'(cfg);
  endfunction

  // Dijkstra over the mirrored matrix: lowest index wins on equal cost,
  // relaxation only on strictly lower cost.
  function automatic hop_result_t route_hop(input logic [CFG_BITS-1:0] cfg,
                                            input logic [NODE_BITS-1:0] src_in,
                                            input logic [NODE_BITS-1:0] dst_in);
    int          n, src, dst, u, c, cur, steps;
    int          cost[NODE_LIMIT];
    int          prev[NODE_LIMIT];
    bit          settled[NODE_LIMIT];
    bit          seen[NODE_LIMIT];
    bit          found;
    hop_result_t r;
    n   = effective_nodes(cfg);
    src = (int'(src_in) >= n) ? n - 1 : int'(src_in);
    dst = (int'(dst_in) >= n) ? n - 1 : int'(dst_in);
    for (int i = 0; i < NODE_LIMIT; i++) begin
      cost[i]    = 0;
      prev[i]    = NO_PRED;
      settled[i] = 1'b0;
      seen[i]    = 1'b0;
    end
    seen[src] = 1'b1;
    for (int round = 0; round < n; round++) begin
      found = 1'b0;
      u     = 0;
      for (int i = 0; i < n; i++) begin
        if (!settled[i] && seen[i] && (!found || cost[i] < cost[u])) begin
          found = 1'b1;
          u     = i;
        end
      end
      if (!found) break;
      settled[u] = 1'b1;
      for (int v = 0; v < n; v++) begin
        if (!settled[v] && weight_model[u][v] != 0) begin
          c = cost[u] + int'(weight_model[u][v]);
          if (!seen[v] || c < cost[v]) begin
            cost[v] = c;
            seen[v] = 1'b1;
            prev[v] = u;
          end
        end
      end
    end
    if (prev[dst] == NO_PRED) begin
      r.hop     = NODE_BITS'(dst);
      r.no_path = 1'b1;
      return r;
    end
    cur   = dst;
    steps = 0;
    while (prev[cur] != src && prev[cur] != NO_PRED && steps < n) begin
      cur = prev[cur];
      steps++;
    end
    r.hop     = NODE_BITS'((prev[cur] == src) ? cur : dst);
    r.no_path = 1'b0;
    return r;
  endfunction

  task automatic push_write(input int r, input int c, input int w);
    hop_request_t req;
    req        = '0;
    req.op     = OP_WRITE;
    req.row    = NODE_BITS'(r);
    req.col    = NODE_BITS'(c);
    req.weight = EDGE_BITS'(w);
    req.src    = NODE_BITS'($urandom_range(15));
    req.dst    = NODE_BITS'($urandom_range(15));
    pending_requests.push_back(req);
  endtask

  task automatic push_solve(input int s, input int e);
    hop_request_t req;
    req        = '0;
    req.op     = OP_SOLVE;
    req.row    = NODE_BITS'($urandom_range(15));
    req.col    = NODE_BITS'($urandom_range(15));
    req.weight = EDGE_BITS'($urandom_range(255));
    req.src    = NODE_BITS'(s);
    req.dst    = NODE_BITS'(e);
    pending_requests.push_back(req);
  endtask

  // Mostly writes inside the active node range so the searches see real
  // graphs; small weights give plenty of equal-cost ties.
  task automatic fill_random(input int count, input int n);
    int roll, w;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 22) begin
        if ($urandom_range(9) == 0)
          push_solve($urandom_range(15), $urandom_range(15));
        else
          push_solve($urandom_range(n - 1), $urandom_range(n - 1));
      end else if (roll < 32) begin
        push_write($urandom_range(15), $urandom_range(15), $urandom_range(255));
      end else begin
        roll = $urandom_range(99);
        if (roll < 30)      w = $urandom_range(3, 1);
        else if (roll < 45) w = 0;
        else if (roll < 55) w = 255;
        else                w = $urandom_range(255, 1);
        push_write($urandom_range(n - 1), $urandom_range(n - 1), w);
      end
    end
  endtask

  task automatic wait_idle();
    repeat (4) @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || in_stall ||
           expected_hops.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_node_count(input logic [CFG_BITS-1:0] value);
    wait_idle();
    repeat (SETTLE) @(negedge clk);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 69;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 69;
      end
      default: begin
        send_idle_pct  = 14;
        recv_stall_pct = 14;
      end
    endcase
  endtask

  initial begin
    int phase_cfg[11];
    phase_cfg = '{16, 0, 31, 5, 1, 16, 8, 2, 17, 16, 3};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_node_count(5'd4);
    set_idle_mode(0);
    push_solve(0, 0);
    push_solve(0, 3);
    push_write(0, 1, 255);
    push_write(1, 3, 255);
    push_write(0, 2, 1);
    push_write(2, 3, 1);
    push_solve(0, 3);
    push_write(15, 15, 255);
    push_write(15, 0, 0);
    push_solve(15, 9);
    push_solve(3, 0);
    push_write(0, 1, 1);
    push_write(1, 3, 1);
    push_solve(0, 3);
    push_write(1, 3, 0);
    push_solve(0, 3);
    push_write(3, 0, 170);
    push_write(2, 0, 85);
    push_solve(2, 1);
    push_solve(15, 15);

    for (int p = 0; p < 11; p++) begin
      set_node_count(phase_cfg[p][CFG_BITS-1:0]);
      set_idle_mode(p % 4);
      fill_random(140, effective_nodes(phase_cfg[p][CFG_BITS-1:0]));
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (expected_hops.size() != 0) begin
      $display("%0d expected results never arrived", expected_hops.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk) begin : drive_requests
    hop_request_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req         = pending_requests.pop_front();
        in_valid    <= 1'b1;
        operation   <= req.op;
        row_node    <= req.row;
        col_node    <= req.col;
        edge_weight <= req.weight;
        start_node  <= req.src;
        end_node    <= req.dst;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : scoreboard
    hop_result_t want;
    if (rst) begin
      node_cfg = 5'd1;
      for (int r = 0; r < NODE_LIMIT; r++)
        for (int c = 0; c < NODE_LIMIT; c++)
          weight_model[r][c] = '0;
    end else begin
      if (cfg_write) node_cfg = cfg_data;
      if (in_valid && !in_stall) begin
        if (operation == OP_WRITE)
          weight_model[row_node][col_node] = edge_weight;
        else
          expected_hops.push_back(route_hop(node_cfg, start_node, end_node));
      end
      if (out_valid && !out_stall) begin
        if (expected_hops.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: hop %0d no_path %0b", next_node, no_path);
        end else begin
          want = expected_hops.pop_front();
          if (next_node !== want.hop || no_path !== want.no_path) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected hop %0d no_path %0b, got hop %0d no_path %0b",
                       want.hop, want.no_path, next_node, no_path);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
